>>> sv/aod_pkg.sv
`timescale 1ns / 1ps
// Shared types and constants for the alpha outline detector.
// Used by aod_scan, aod_window, aod_outreg and alpha_outline_detector.

package aod_pkg;

  localparam int COL_W        = 10;
  localparam int ROW_W        = 12;
  localparam int MAX_WIDTH    = 1 << COL_W;
  localparam int MAX_HEIGHT   = 1 << ROW_W;
  localparam int WIDTH_REG_W  = COL_W + 1;
  localparam int HEIGHT_REG_W = ROW_W + 1;
  localparam int ALPHA_W      = 8;
  localparam int CFG_DATA_W   = HEIGHT_REG_W;
  localparam int CFG_IDX_W    = 2;
  localparam int WIN_W        = 9;

  localparam logic [WIDTH_REG_W-1:0]  WIDTH_RESET     = WIDTH_REG_W'(1024);
  localparam logic [HEIGHT_REG_W-1:0] HEIGHT_RESET    = HEIGHT_REG_W'(1024);
  localparam logic [ALPHA_W-1:0]      THRESHOLD_RESET = 8'hFF;
  localparam logic [WIN_W-1:0]        WIN_ALL_OPAQUE  = 9'h1FF;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_IMAGE_WIDTH      = 2'd0,
    CFG_IMAGE_HEIGHT     = 2'd1,
    CFG_OPAQUE_THRESHOLD = 2'd2
  } cfg_index_t;

  // Which of the up to three results of one pixel is being sent.
  typedef enum logic [1:0] {
    SLOT_INNER = 2'd0,
    SLOT_EDGE  = 2'd1,
    SLOT_SELF  = 2'd2
  } slot_t;

  typedef struct packed {
    logic [COL_W-1:0] col;
    logic [ROW_W-1:0] row;
    logic             opaque;
    logic             col_nonzero;
    logic             row_nonzero;
    logic             col_last;
    logic             row_last;
    logic             near_border;
  } pixel_t;

  typedef struct packed {
    logic [COL_W-1:0] col;
    logic [ROW_W-1:0] row;
    logic             outline;
    logic             last;
  } result_t;

endpackage

>>> sv/aod_scan.sv
`timescale 1ns / 1ps
// Configuration registers, raster position counters and pixel thresholding.
// Depends on aod_pkg.

module aod_scan (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          cfg_write,
  input  logic [aod_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [aod_pkg::CFG_DATA_W-1:0] cfg_data,
  input  logic [aod_pkg::ALPHA_W-1:0]   alpha,
  input  logic                          accept,
  output aod_pkg::pixel_t               pix,
  output logic                          restart
);

  logic [aod_pkg::WIDTH_REG_W-1:0]  image_width;
  logic [aod_pkg::HEIGHT_REG_W-1:0] image_height;
  logic [aod_pkg::ALPHA_W-1:0]      opaque_threshold;
  logic [aod_pkg::COL_W-1:0]        col;
  logic [aod_pkg::ROW_W-1:0]        row;
  logic [aod_pkg::COL_W-1:0]        col_next;
  logic [aod_pkg::ROW_W-1:0]        row_next;
  logic [aod_pkg::WIDTH_REG_W-1:0]  eff_width;
  logic [aod_pkg::HEIGHT_REG_W-1:0] eff_height;
  logic [aod_pkg::COL_W-1:0]        col_max;
  logic [aod_pkg::ROW_W-1:0]        row_max;
  aod_pkg::cfg_index_t              cfg_sel;

  assign cfg_sel = aod_pkg::cfg_index_t'(cfg_index);

  always_comb begin
    restart = 1'b0;
    if (cfg_write) begin
      case (cfg_sel)
        aod_pkg::CFG_IMAGE_WIDTH:  restart = 1'b1;
        aod_pkg::CFG_IMAGE_HEIGHT: restart = 1'b1;
        default:                   restart = 1'b0;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      image_width      <= aod_pkg::WIDTH_RESET;
      image_height     <= aod_pkg::HEIGHT_RESET;
      opaque_threshold <= aod_pkg::THRESHOLD_RESET;
    end else if (cfg_write) begin
      case (cfg_sel)
        aod_pkg::CFG_IMAGE_WIDTH:
          image_width <= cfg_data[aod_pkg::WIDTH_REG_W-1:0];
        aod_pkg::CFG_IMAGE_HEIGHT:
          image_height <= cfg_data[aod_pkg::HEIGHT_REG_W-1:0];
        aod_pkg::CFG_OPAQUE_THRESHOLD:
          opaque_threshold <= cfg_data[aod_pkg::ALPHA_W-1:0];
        default: ;
      endcase
    end
  end

  // Out-of-range geometry is clamped: zero acts as one, oversize as the maximum.
  always_comb begin
    if (image_width == '0) begin
      eff_width = aod_pkg::WIDTH_REG_W'(1);
    end else if (image_width > aod_pkg::WIDTH_REG_W'(aod_pkg::MAX_WIDTH)) begin
      eff_width = aod_pkg::WIDTH_REG_W'(aod_pkg::MAX_WIDTH);
    end else begin
      eff_width = image_width;
    end
    if (image_height == '0) begin
      eff_height = aod_pkg::HEIGHT_REG_W'(1);
    end else if (image_height > aod_pkg::HEIGHT_REG_W'(aod_pkg::MAX_HEIGHT)) begin
      eff_height = aod_pkg::HEIGHT_REG_W'(aod_pkg::MAX_HEIGHT);
    end else begin
      eff_height = image_height;
    end
  end

  assign col_max = aod_pkg::COL_W'(eff_width - aod_pkg::WIDTH_REG_W'(1));
  assign row_max = aod_pkg::ROW_W'(eff_height - aod_pkg::HEIGHT_REG_W'(1));

  always_comb begin
    pix.col         = col;
    pix.row         = row;
    pix.opaque      = (alpha >= opaque_threshold);
    pix.col_nonzero = (col != '0);
    pix.row_nonzero = (row != '0);
    pix.col_last    = (col == col_max);
    pix.row_last    = (row == row_max);
    // The inner result is for the pixel up and left; it lies on the first
    // column or first row exactly when this pixel is in column or row one.
    pix.near_border = (col == aod_pkg::COL_W'(1)) || (row == aod_pkg::ROW_W'(1));
  end

  always_comb begin
    col_next = col + aod_pkg::COL_W'(1);
    row_next = row;
    if (pix.col_last) begin
      col_next = '0;
      row_next = pix.row_last ? '0 : row + aod_pkg::ROW_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (rst || restart) begin
      col <= '0;
      row <= '0;
    end else if (accept) begin
      col <= col_next;
      row <= row_next;
    end
  end

endmodule

>>> sv/aod_window.sv
`timescale 1ns / 1ps
// Line store memory, 3x3 opacity window and per-pixel result sequencing.
// Depends on aod_pkg.

module aod_window (
  input  logic              clk,
  input  logic              rst,
  input  logic              pixel_valid,
  output logic              pixel_stall,
  input  aod_pkg::pixel_t   pix,
  input  logic              restart,
  input  logic              res_ready,
  output logic              res_load,
  output aod_pkg::result_t  res
);

  // Each entry holds {two rows above, one row above} opacity for a column.
  logic [1:0] line_mem [aod_pkg::MAX_WIDTH];
  logic [1:0] mem_q;

  logic                     s1_valid;
  aod_pkg::pixel_t          s1;
  logic [2:0]               pending;
  logic [2:0]               remaining;
  logic                     byp_hit;
  logic [1:0]               byp_data;
  logic [aod_pkg::WIN_W-1:0] win;
  logic [aod_pkg::WIN_W-1:0] win_next;

  logic                     acc;
  logic                     s1_leave;
  logic                     above;
  logic                     two_above;
  logic [1:0]               wdata;
  logic                     inner_outline;
  logic                     last;
  aod_pkg::slot_t           slot;

  assign acc         = pixel_valid && !pixel_stall;
  assign pixel_stall = s1_valid && !s1_leave;

  // A read issued at the same edge as the write to that entry sees old data;
  // the bypass register supplies the value being written instead.
  assign above     = byp_hit ? byp_data[0] : mem_q[0];
  assign two_above = byp_hit ? byp_data[1] : mem_q[1];
  assign wdata     = {above, s1.opaque};

  assign win_next      = {win[aod_pkg::WIN_W-4:0], s1.opaque, above, two_above};
  assign inner_outline = win_next[4] &&
                         (s1.near_border || (win_next != aod_pkg::WIN_ALL_OPAQUE));

  always_comb begin
    if (pending[0]) begin
      slot = aod_pkg::SLOT_INNER;
    end else if (pending[1]) begin
      slot = aod_pkg::SLOT_EDGE;
    end else begin
      slot = aod_pkg::SLOT_SELF;
    end
  end

  always_comb begin
    remaining   = pending;
    res.col     = s1.col;
    res.row     = s1.row;
    res.outline = s1.opaque;
    case (slot)
      aod_pkg::SLOT_INNER: begin
        remaining[0] = 1'b0;
        res.col      = s1.col - aod_pkg::COL_W'(1);
        res.row      = s1.row - aod_pkg::ROW_W'(1);
        res.outline  = inner_outline;
      end
      aod_pkg::SLOT_EDGE: begin
        remaining[1] = 1'b0;
        res.row      = s1.row - aod_pkg::ROW_W'(1);
        res.outline  = above;
      end
      aod_pkg::SLOT_SELF: begin
        remaining[2] = 1'b0;
      end
      default: begin
        remaining = '0;
      end
    endcase
    last     = (remaining == '0);
    res.last = last;
  end

  assign res_load = s1_valid && (pending != '0) && res_ready;
  assign s1_leave = s1_valid && ((pending == '0) || (res_load && last));

  always_ff @(posedge clk) begin
    if (s1_leave) begin
      line_mem[s1.col] <= wdata;
    end
    if (acc) begin
      mem_q <= line_mem[pix.col];
    end
  end

  always_ff @(posedge clk) begin
    if (acc) begin
      s1       <= pix;
      byp_data <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
      pending  <= '0;
      byp_hit  <= 1'b0;
    end else begin
      if (acc) begin
        s1_valid <= 1'b1;
        pending  <= {pix.row_last,
                     pix.col_last && pix.row_nonzero,
                     pix.col_nonzero && pix.row_nonzero};
        byp_hit  <= s1_leave && (s1.col == pix.col);
      end else begin
        if (s1_leave) begin
          s1_valid <= 1'b0;
          byp_hit  <= 1'b0;
        end
        if (res_load) begin
          pending <= remaining;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst || restart) begin
      win <= '0;
    end else if (s1_leave) begin
      win <= win_next;
    end
  end

  bypass_needs_item: assert property (@(posedge clk) disable iff (rst)
    byp_hit |-> s1_valid)
    else $error("bypass flag set with no pixel in the window stage");

  leave_empties_stage: assert property (@(posedge clk) disable iff (rst)
    (s1_leave && !acc) |=> !s1_valid)
    else $error("window stage still full after its pixel left");

  held_pending_only_shrinks: assert property (@(posedge clk) disable iff (rst)
    (s1_valid && !s1_leave) |=> ((pending & ~$past(pending)) == 3'b000))
    else $error("pending results grew while the pixel was held");

  idle_has_no_pending: assert property (@(posedge clk) disable iff (rst)
    !s1_valid |-> (pending == 3'b000))
    else $error("results pending with no pixel in the window stage");

endmodule

>>> sv/aod_outreg.sv
`timescale 1ns / 1ps
// Output register that holds one result beat until the receiver takes it.
// Depends on aod_pkg.

module aod_outreg (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      load,
  input  aod_pkg::result_t          res,
  output logic                      ready,
  output logic                      result_valid,
  input  logic                      result_stall,
  output logic [aod_pkg::COL_W-1:0] pixel_column,
  output logic [aod_pkg::ROW_W-1:0] pixel_row,
  output logic                      is_outline,
  output logic                      last_of_run
);

  aod_pkg::result_t held;

  assign ready = !result_valid || !result_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (ready) begin
      result_valid <= load;
    end
  end

  always_ff @(posedge clk) begin
    if (ready && load) begin
      held <= res;
    end
  end

  assign pixel_column = held.col;
  assign pixel_row    = held.row;
  assign is_outline   = held.outline;
  assign last_of_run  = held.last;

endmodule

>>> sv/alpha_outline_detector.sv
`timescale 1ns / 1ps
// Alpha outline detector top level: scan counters, line store window, output register.
// Depends on aod_pkg, aod_scan, aod_window and aod_outreg.

// Takes one alpha beat per clock in raster order and returns, for every pixel,
// a beat with its column, row and outline flag (opaque and on the image border
// or next to a non-opaque pixel among its eight neighbors). A pixel's result
// usually comes out one row and one column late, so the beats of one input can
// carry other coordinates; an input causes zero to three result beats, the last
// one marked by last_of_run. An input is registered in the window stage and its
// results in the output register. Inputs are taken one per clock while each
// causes at most one result and result_stall is low; in an image of two or more
// rows and columns the last column of each later row causes two, every pixel of
// the last row after its first causes two, and the last pixel causes three. As
// the result port carries at most one beat per clock, such pixels stall the input.
// The two previous rows live in a single 1024 x 2-bit memory read and written
// once per pixel, with a bypass for back-to-back access to the same column
// when the image is one pixel wide. Writing image_width or image_height
// restarts the frame at pixel (0,0); the line store keeps its contents, so
// rows above the first one of a new geometry are not used for decisions until
// they are written again.

module alpha_outline_detector (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           cfg_write,
  input  logic [aod_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [aod_pkg::CFG_DATA_W-1:0] cfg_data,
  input  logic                           pixel_valid,
  output logic                           pixel_stall,
  input  logic [aod_pkg::ALPHA_W-1:0]    alpha,
  output logic                           result_valid,
  input  logic                           result_stall,
  output logic [aod_pkg::COL_W-1:0]      pixel_column,
  output logic [aod_pkg::ROW_W-1:0]      pixel_row,
  output logic                           is_outline,
  output logic                           last_of_run
);

  aod_pkg::pixel_t  pix;
  aod_pkg::result_t res;
  logic             restart;
  logic             accept;
  logic             res_load;
  logic             res_ready;

  assign accept = pixel_valid && !pixel_stall;

  aod_scan u_scan (
    .clk       (clk),
    .rst       (rst),
    .cfg_write (cfg_write),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .alpha     (alpha),
    .accept    (accept),
    .pix       (pix),
    .restart   (restart)
  );

  aod_window u_window (
    .clk         (clk),
    .rst         (rst),
    .pixel_valid (pixel_valid),
    .pixel_stall (pixel_stall),
    .pix         (pix),
    .restart     (restart),
    .res_ready   (res_ready),
    .res_load    (res_load),
    .res         (res)
  );

  aod_outreg u_outreg (
    .clk          (clk),
    .rst          (rst),
    .load         (res_load),
    .res          (res),
    .ready        (res_ready),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .pixel_column (pixel_column),
    .pixel_row    (pixel_row),
    .is_outline   (is_outline),
    .last_of_run  (last_of_run)
  );

endmodule
